[hdl/owmst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package owmst_pkg;

	localparam int TICK_W = 10;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 16;
	localparam int MODE_W = 2;

	// Command codes carried in tuser; the same codes name the running operation.
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

	localparam int RESET_LOW_TICKS = 480;
	localparam logic [TICK_W-1:0] RESET_LOW_LEN = TICK_W'((RESET_LOW_TICKS < 1) ? 1 :
		((RESET_LOW_TICKS > 1023) ? 1023 : RESET_LOW_TICKS));

	localparam logic [TICK_W-1:0] SLOT_LOW_SHORT = 10'd6;
	localparam logic [TICK_W-1:0] SLOT_LOW_LONG = 10'd60;
	localparam logic [TICK_W-1:0] WR1_REC_LEN = 10'd64;
	localparam logic [TICK_W-1:0] WR0_REC_LEN = 10'd10;
	localparam logic [TICK_W-1:0] RD_WAIT_LEN = 10'd9;
	localparam logic [TICK_W-1:0] RD_REC_LEN = 10'd55;
	localparam logic [TICK_W-1:0] RST_WAIT_LEN = 10'd70;
	localparam logic [TICK_W-1:0] RST_REC_LEN = 10'd410;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_LOW  = 4'b0010,
		PH_WAIT = 4'b0100,
		PH_REC  = 4'b1000
	} phase_t;

	// Length in ticks of the given phase of the given operation.
	function automatic logic [TICK_W-1:0] phase_len(phase_t ph, logic [MODE_W-1:0] op,
		logic bit_one);
		logic [TICK_W-1:0] len;
		case (ph)
			PH_LOW: begin
				if (op == MODE_RESET) len = RESET_LOW_LEN;
				else if (op == MODE_WRITE) len = bit_one ? SLOT_LOW_SHORT : SLOT_LOW_LONG;
				else len = SLOT_LOW_SHORT;
			end
			PH_WAIT: begin
				len = (op == MODE_RESET) ? RST_WAIT_LEN : RD_WAIT_LEN;
			end
			default: begin
				if (op == MODE_RESET) len = RST_REC_LEN;
				else if (op == MODE_WRITE) len = bit_one ? WR1_REC_LEN : WR0_REC_LEN;
				else len = RD_REC_LEN;
			end
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

[hdl/one_wire_master_slot_timer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: data_byte, line_level
// m_*       out  m_tvalid/m_tready  tdata: drive_low, busy_res, done_res, read_byte,
//                                   presence_found, rejected
//
// One word in, one word out. A tick is accepted every clock while the result
// register is empty or being drained, so the sustained rate is one tick per cycle;
// the next-state logic of the slot timer sits between the input port and the
// result register. Reset leaves the master idle with all counters at zero.
// A stall on the output holds s_tready low; no tick is taken until the result drains.

module one_wire_master_slot_timer_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// [7:0] data_byte, [8] line_level, [15:9] zero
	input  wire  [owmst_pkg::IN_DATA_W-1:0]     s_tdata,
	// [1:0] mode
	input  wire  [owmst_pkg::MODE_W-1:0]        s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_byte,
	// [11] presence_found, [12] rejected, [15:13] zero
	output logic [owmst_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import owmst_pkg::*;

	phase_t             phase_q, phase_n, ph;
	logic [TICK_W-1:0]  tick_q, tick_n, cnt, cnt_inc;
	logic [2:0]         bit_q, bit_n;
	logic [7:0]         shift_q, shift_n;
	logic [MODE_W-1:0]  op_q, op_n;
	logic               pres_q, pres_n;
	logic [7:0]         read_hold_q, read_hold_n;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] result_q;

	logic [MODE_W-1:0]  mode;
	logic [7:0]         data_byte;
	logic               line_level;
	logic               accept, start;
	logic               drive, busy, done, rej;

	assign mode = s_tuser;
	assign data_byte = s_tdata[7:0];
	assign line_level = s_tdata[8];

	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = result_q;

	always_comb begin
		start = (phase_q == PH_IDLE) && (mode != MODE_TICK);
		rej = (phase_q != PH_IDLE) && (mode != MODE_TICK);
		ph = start ? PH_LOW : phase_q;
		cnt = start ? '0 : tick_q;
		bit_n = start ? 3'd0 : bit_q;
		op_n = start ? mode : op_q;
		shift_n = start ? ((mode == MODE_WRITE) ? data_byte : 8'd0) : shift_q;
		pres_n = pres_q;
		read_hold_n = read_hold_q;
		phase_n = ph;
		tick_n = cnt;
		drive = 1'b0;
		busy = 1'b0;
		done = 1'b0;
		cnt_inc = cnt + 1'b1;
		if (ph != PH_IDLE) begin
			busy = 1'b1;
			drive = (ph == PH_LOW);
			// First recovery tick is the sample point.
			if (ph == PH_REC && cnt == '0) begin
				if (op_n == MODE_RESET) pres_n = !line_level;
				else if (op_n == MODE_READ) shift_n = {line_level, shift_n[7:1]};
			end
			if (cnt_inc >= phase_len(ph, op_n, shift_n[0])) begin
				tick_n = '0;
				case (ph)
					PH_LOW: phase_n = (op_n == MODE_WRITE) ? PH_REC : PH_WAIT;
					PH_WAIT: phase_n = PH_REC;
					default: begin
						if (op_n == MODE_RESET) begin
							phase_n = PH_IDLE;
							done = 1'b1;
						end else begin
							if (op_n == MODE_WRITE) shift_n = {1'b0, shift_n[7:1]};
							if (bit_n == 3'd7) begin
								if (op_n == MODE_READ) read_hold_n = shift_n;
								phase_n = PH_IDLE;
								bit_n = 3'd0;
								done = 1'b1;
							end else begin
								bit_n = bit_n + 3'd1;
								phase_n = PH_LOW;
							end
						end
					end
				endcase
			end else begin
				tick_n = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			op_q <= MODE_TICK;
			pres_q <= 1'b0;
			read_hold_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				tick_q <= tick_n;
				bit_q <= bit_n;
				shift_q <= shift_n;
				op_q <= op_n;
				pres_q <= pres_n;
				read_hold_q <= read_hold_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= {3'b000, rej, pres_n, read_hold_n, done, busy, drive};
		end
	end

	// Done, rejection and drive only happen inside an operation.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1])
		else $error("done without busy");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[0] || m_tdata[12]) |-> m_tdata[1])
		else $error("drive or reject outside an operation");

	a_start_low: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_IDLE && mode != MODE_TICK
		|=> phase_q == PH_LOW && op_q == $past(mode))
		else $error("command did not start a low phase");

	a_idle_bit: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_q == 3'd0)
		else $error("bit index left over in idle");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import owmst_pkg::*;

	// Result word as the block packs it, rejected in bit 12 down to drive_low in bit 0.
	typedef struct packed {
		logic       rejected;
		logic       presence_found;
		logic [7:0] read_byte;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} bus_result_t;

	// One row of the directed table. A repeat count of zero sends the row's word
	// over and over until the running operation reports done.
	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [7:0]        data;
		logic              lvl;
		int                reps;
		bit                typed;
		bus_result_t       want;
	} stim_row_t;

	localparam int CYCLE_LIMIT = 100_000;
	localparam int RANDOM_ITEMS = 750;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int QUIET_START = 1_500;
	localparam int QUIET_END = 2_500;

	localparam bus_result_t RES_IDLE = 13'h0000;
	localparam bus_result_t RES_LOW = 13'h0003;
	localparam bus_result_t RES_LOW_REJECT = 13'h1003;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [MODE_W-1:0]      s_tuser = MODE_TICK;
	logic                   m_tready = 1'b0;
	wire                    s_tready;
	wire                    m_tvalid;
	wire [OUT_DATA_W-1:0]   m_tdata;

	one_wire_master_slot_timer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	bus_result_t expected_bus_words[$];
	stim_row_t   directed_rows[19];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          holdoff_asks = 0;
	int          holdoff_seen = 0;
	int          hold_left = 0;

	// Own copy of the bus master state.
	phase_t            ow_phase = PH_IDLE;
	logic [TICK_W-1:0] ow_ticks = '0;
	logic [2:0]        ow_bit = '0;
	logic [7:0]        ow_shift = '0;
	logic [MODE_W-1:0] ow_op = MODE_TICK;
	logic              ow_presence = 1'b0;
	logic [7:0]        ow_read_hold = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [TICK_W-1:0] slot_length();
		logic [TICK_W-1:0] len;
		if (ow_phase == PH_LOW) begin
			if (ow_op == MODE_RESET) len = RESET_LOW_LEN;
			else if (ow_op == MODE_WRITE) len = ow_shift[0] ? SLOT_LOW_SHORT : SLOT_LOW_LONG;
			else len = SLOT_LOW_SHORT;
		end else if (ow_phase == PH_WAIT) begin
			len = (ow_op == MODE_RESET) ? RST_WAIT_LEN : RD_WAIT_LEN;
		end else if (ow_op == MODE_RESET) begin
			len = RST_REC_LEN;
		end else if (ow_op == MODE_WRITE) begin
			len = ow_shift[0] ? WR1_REC_LEN : WR0_REC_LEN;
		end else begin
			len = RD_REC_LEN;
		end
		return len;
	endfunction

	// Advances the master by one microsecond tick and returns the word it should produce.
	task automatic bus_master_tick(input logic [MODE_W-1:0] mode, input logic [7:0] data,
		input logic lvl, output bus_result_t r);
		r = '0;
		if (ow_phase != PH_IDLE) begin
			if (mode != MODE_TICK) r.rejected = 1'b1;
		end else if (mode != MODE_TICK) begin
			ow_phase = PH_LOW;
			ow_ticks = '0;
			ow_bit = '0;
			ow_op = mode;
			ow_shift = (mode == MODE_WRITE) ? data : 8'h00;
		end
		if (ow_phase != PH_IDLE) begin
			r.busy_res = 1'b1;
			r.drive_low = (ow_phase == PH_LOW);
			// The first tick of recovery is the sample point.
			if (ow_phase == PH_REC && ow_ticks == '0) begin
				if (ow_op == MODE_RESET) ow_presence = ~lvl;
				else if (ow_op == MODE_READ) ow_shift = {lvl, ow_shift[7:1]};
			end
			ow_ticks = ow_ticks + 1'b1;
			if (ow_ticks >= slot_length()) begin
				ow_ticks = '0;
				if (ow_phase == PH_LOW) begin
					ow_phase = (ow_op == MODE_WRITE) ? PH_REC : PH_WAIT;
				end else if (ow_phase == PH_WAIT) begin
					ow_phase = PH_REC;
				end else if (ow_op == MODE_RESET) begin
					ow_phase = PH_IDLE;
					r.done_res = 1'b1;
				end else begin
					if (ow_op == MODE_WRITE) ow_shift = ow_shift >> 1;
					if (ow_bit == 3'd7) begin
						if (ow_op == MODE_READ) ow_read_hold = ow_shift;
						ow_phase = PH_IDLE;
						ow_bit = '0;
						r.done_res = 1'b1;
					end else begin
						ow_bit = ow_bit + 1'b1;
						ow_phase = PH_LOW;
					end
				end
			end
		end
		r.read_byte = ow_read_hold;
		r.presence_found = ow_presence;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("cycle %0d: %s: got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
	endtask

	// Offers one tick word, waits for the handshake and predicts its result.
	task automatic send_tick(input logic [MODE_W-1:0] mode, input logic [7:0] data,
		input logic lvl, output bus_result_t r);
		while (!(cycle_count >= QUIET_START && cycle_count < QUIET_END) &&
			$urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {7'b0, lvl, data};
		do @(posedge clk); while (!s_tready);
		bus_master_tick(mode, data, lvl, r);
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] word);
		bus_result_t got, want;
		got = word[12:0];
		if (expected_bus_words.size() == 0) begin
			report_mismatch("word with nothing expected", word, 16'h0);
			return;
		end
		want = expected_bus_words.pop_front();
		if (word[15:13] !== 3'b000) report_mismatch("pad bits", 16'(word[15:13]), 16'h0);
		if (got.drive_low !== want.drive_low)
			report_mismatch("drive_low", 16'(got.drive_low), 16'(want.drive_low));
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
		if (got.done_res !== want.done_res)
			report_mismatch("done_res", 16'(got.done_res), 16'(want.done_res));
		if (got.read_byte !== want.read_byte)
			report_mismatch("read_byte", 16'(got.read_byte), 16'(want.read_byte));
		if (got.presence_found !== want.presence_found)
			report_mismatch("presence_found", 16'(got.presence_found),
				16'(want.presence_found));
		if (got.rejected !== want.rejected)
			report_mismatch("rejected", 16'(got.rejected), 16'(want.rejected));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result(m_tdata);
	end

	// Receiver: random stalls, one long hold-off on request, and a quiet window.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holdoff_asks != holdoff_seen) begin
			holdoff_seen <= holdoff_asks;
			hold_left <= HOLDOFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (cycle_count >= QUIET_START && cycle_count < QUIET_END) ||
				($urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		stim_row_t         row;
		bus_result_t       res;
		int                n;
		int                cmd_n;
		int                sent;
		int                gap;
		int                pick;
		logic [MODE_W-1:0] op;
		logic [MODE_W-1:0] noise_mode;

		directed_rows = '{
			'{MODE_TICK,  8'hFF, 1'b0, 1, 1'b1, RES_IDLE},
			'{MODE_TICK,  8'h00, 1'b1, 1, 1'b1, RES_IDLE},
			'{MODE_WRITE, 8'hFF, 1'b1, 1, 1'b1, RES_LOW},
			'{MODE_READ,  8'h00, 1'b0, 1, 1'b1, RES_LOW_REJECT},
			'{MODE_TICK,  8'h00, 1'b0, 0, 1'b0, RES_IDLE},
			'{MODE_WRITE, 8'h00, 1'b1, 1, 1'b1, RES_LOW},
			// Reset commands on every tick of the write, the completing tick too.
			'{MODE_RESET, 8'h5A, 1'b1, 0, 1'b0, RES_IDLE},
			'{MODE_RESET, 8'h00, 1'b1, 1, 1'b1, RES_LOW},
			'{MODE_TICK,  8'h00, 1'b0, 0, 1'b0, RES_IDLE},
			'{MODE_RESET, 8'hFF, 1'b0, 1, 1'b0, RES_IDLE},
			'{MODE_TICK,  8'h3C, 1'b1, 0, 1'b0, RES_IDLE},
			'{MODE_READ,  8'hFF, 1'b1, 1, 1'b0, RES_IDLE},
			'{MODE_TICK,  8'h00, 1'b1, 0, 1'b0, RES_IDLE},
			'{MODE_READ,  8'h00, 1'b0, 1, 1'b0, RES_IDLE},
			'{MODE_WRITE, 8'hFF, 1'b0, 0, 1'b0, RES_IDLE},
			// The line level must not matter during write slots.
			'{MODE_WRITE, 8'hA5, 1'b0, 1, 1'b0, RES_IDLE},
			'{MODE_TICK,  8'h00, 1'b0, 0, 1'b0, RES_IDLE},
			'{MODE_READ,  8'h81, 1'b1, 1, 1'b0, RES_IDLE},
			'{MODE_TICK,  8'hFF, 1'b0, 0, 1'b0, RES_IDLE}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed_rows); i++) begin
			row = directed_rows[i];
			n = 0;
			do begin
				send_tick(row.mode, row.data, row.lvl, res);
				expected_bus_words.push_back(row.typed ? row.want : res);
				n++;
			end while (row.reps == 0 ? !res.done_res : n < row.reps);
		end

		// Random part: whole operations with random line levels, a little noise of
		// commands while busy, and short idle gaps between operations.
		sent = 0;
		for (cmd_n = 0; sent < RANDOM_ITEMS; cmd_n++) begin
			if (cmd_n == 0) holdoff_asks <= holdoff_asks + 1;
			pick = $urandom_range(99);
			op = (pick < 15) ? MODE_RESET : ((pick < 55) ? MODE_WRITE : MODE_READ);
			send_tick(op, 8'($urandom_range(255)), 1'($urandom_range(1)), res);
			expected_bus_words.push_back(res);
			sent++;
			while (!res.done_res) begin
				noise_mode = MODE_TICK;
				if ($urandom_range(99) < 2) noise_mode = 2'($urandom_range(3, 1));
				send_tick(noise_mode, 8'($urandom_range(255)), 1'($urandom_range(1)), res);
				expected_bus_words.push_back(res);
				sent++;
			end
			gap = $urandom_range(3);
			repeat (gap) begin
				send_tick(MODE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), res);
				expected_bus_words.push_back(res);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (expected_bus_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_bus_words.size() != 0)
			report_mismatch("words never produced", 16'(expected_bus_words.size()), 16'h0);

		if (mismatch_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
